@@ design/psc_pkg.sv @@
// shared widths, register indexes and multiplier control types
// for the pressure sensor compensation core; no dependencies
`default_nettype none

package psc_pkg;

    localparam int RAW_W  = 24;
    localparam int CAL_W  = 16;
    localparam int VAR_W  = 3;
    localparam int IDX_W  = 3;
    localparam int RES_W  = 32;

    // shift-add multiplier: signed multiplicand, unsigned multiplier
    localparam int MUL_AW = 50;
    localparam int MUL_BW = 25;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int CNT_W  = $clog2(MUL_BW + 1);

    localparam logic [IDX_W-1:0] REG_SENS_CAL   = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFFS_CAL   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SENS_TCO   = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFFS_TCO   = 3'd3;
    localparam logic [IDX_W-1:0] REG_TEMP_REF   = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEMP_COEFF = 3'd5;
    localparam logic [IDX_W-1:0] REG_VARIANT    = 3'd6;

    localparam logic [VAR_W-1:0] VC_02 = 3'd1;
    localparam logic [VAR_W-1:0] VC_05 = 3'd2;
    localparam logic [VAR_W-1:0] VC_14 = 3'd3;
    localparam logic [VAR_W-1:0] VC_30 = 3'd4;

    localparam logic OP_TEMP = 1'b0;
    localparam logic OP_PRES = 1'b1;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } t_mul_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

endpackage

`default_nettype wire

@@ design/psc_if.sv @@
// valid/ready channels of the compensation core: input, result and config
// depends on psc_pkg
`default_nettype none

interface psc_in_if;
    import psc_pkg::*;
    logic             valid;
    logic             ready;
    logic             op;
    logic [RAW_W-1:0] raw_sample;
    modport source (output valid, op, raw_sample, input ready);
    modport sink   (input valid, op, raw_sample, output ready);
endinterface

interface psc_out_if;
    import psc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    result_kind;
    logic signed [RES_W-1:0] temp_first_order;
    logic signed [RES_W-1:0] temp_second_order;
    logic signed [RES_W-1:0] pressure_value;
    modport source (output valid, result_kind, temp_first_order, temp_second_order,
                    pressure_value, input ready);
    modport sink   (input valid, result_kind, temp_first_order, temp_second_order,
                    pressure_value, output ready);
endinterface

interface psc_cfg_if;
    import psc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CAL_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/psc_smul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on psc_pkg
`default_nettype none

module psc_smul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  psc_pkg::t_mul_cmd                  i_cmd,
    input  logic signed [psc_pkg::MUL_AW-1:0]  i_a,
    input  logic        [psc_pkg::MUL_BW-1:0]  i_b,
    output psc_pkg::t_mul_sts                  o_sts,
    output logic signed [psc_pkg::MUL_PW-1:0]  o_prod
);
    import psc_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MUL_PW-1:0] r_mcand, n_mcand;
    logic [MUL_PW-1:0] r_acc, n_acc;
    logic [MUL_BW-1:0] r_mplier, n_mplier;

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        if (i_cmd.start) begin
            n_busy   = 1'b1;
            n_cnt    = i_cmd.nbits;
            n_mcand  = MUL_PW'(i_a);
            n_mplier = i_b;
            n_acc    = '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = signed'(r_acc);

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy)
        else $error("multiply started while busy");

    a_start_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> (i_cmd.nbits != '0) && (i_cmd.nbits <= CNT_W'(MUL_BW)))
        else $error("multiply length out of range");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> r_busy)
        else $error("multiply did not start");

    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_done)
        else $error("multiply ended without done");

endmodule

`default_nettype wire

@@ design/pressure_sensor_compensation_core.sv @@
// top level of the pressure sensor compensation core
// depends on psc_pkg, psc_if and psc_smul
`default_nettype none

// A temperature beat (op 0) computes dT, first-order temperature and the
// offset and sensitivity terms of the selected sensor variant, applies the
// second-order corrections, keeps the corrected terms and returns both
// temperatures in centidegrees; a pressure beat (op 1) returns compensated
// pressure from the kept terms. All products run one at a time through a
// shared bit-serial shift-add multiplier that consumes one multiplier bit per
// cycle. One beat is worked on at a time; the next beat is taken as soon
// as the result sits in the output register, even if it is not yet taken.
// Config writes are taken in any cycle and are meant to be done while the
// core is idle.
module pressure_sensor_compensation_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psc_in_if.sink    i_in,
    psc_out_if.source o_out,
    psc_cfg_if.sink   i_cfg
);
    import psc_pkg::*;

    localparam int DT_W    = RAW_W + 1;
    localparam int TEMP_W  = 19;
    localparam int DEV_W   = TEMP_W + 1;
    localparam int ADEV_W  = TEMP_W - 1;
    localparam int SQ_W    = 2 * ADEV_W;
    localparam int DT2_W   = 2 * RAW_W;
    localparam int OFS_W   = 44;
    localparam int T2_W    = 20;
    localparam int PQ_W    = 48;
    localparam int SH_W    = 6;
    localparam int REF_SH  = 8;
    localparam int TC_SH   = 23;
    localparam int PS_SH   = 21;
    localparam int PO_SH   = 15;

    localparam logic signed [TEMP_W-1:0] T_NOM  = TEMP_W'(2000);
    localparam logic signed [TEMP_W-1:0] T_VLOW = -TEMP_W'(1500);
    localparam logic signed [TEMP_W-1:0] T_HIGH = TEMP_W'(4500);
    localparam logic signed [DEV_W-1:0]  D_NOM  = DEV_W'(2000);
    localparam logic signed [DEV_W-1:0]  D_VLOW = DEV_W'(1500);
    localparam logic signed [DEV_W-1:0]  D_HIGH = DEV_W'(4500);
    localparam logic signed [PQ_W-1:0]   P_MAX  = PQ_W'(64'sh7FFF_FFFF);
    localparam logic signed [PQ_W-1:0]   P_MIN  = -PQ_W'(64'sh8000_0000);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_WAIT  = 5'b00100,
        S_FIN   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        J_TEMP, J_OFFT, J_SENT, J_DT2, J_D2, J_E2, J_H2,
        J_T2, J_OFF2A, J_OFF2B, J_SEN2A, J_SEN2B, J_PRS
    } t_job;

    typedef enum logic [3:0] {
        V_01 = 4'b0001,
        V_02 = 4'b0010,
        V_05 = 4'b0100,
        V_14 = 4'b1000
    } t_var;

    function automatic logic [ADEV_W-1:0] abs_dev(input logic signed [DEV_W-1:0] v);
        return v[DEV_W-1] ? ADEV_W'(-v) : ADEV_W'(v);
    endfunction

    t_state r_state, n_state;
    t_job   r_job, n_job;

    logic [CAL_W-1:0] r_c1, n_c1, r_c2, n_c2, r_c3, n_c3;
    logic [CAL_W-1:0] r_c4, n_c4, r_c5, n_c5, r_c6, n_c6;
    logic [VAR_W-1:0] r_var, n_var;

    logic                    r_op, n_op;
    logic [RAW_W-1:0]        r_raw, n_raw;
    logic signed [DT_W-1:0]  r_dt, n_dt;
    logic signed [TEMP_W-1:0] r_temp, n_temp;
    logic signed [OFS_W-1:0] r_obase, n_obase, r_sbase, n_sbase;
    logic [DT2_W-1:0]        r_dt2, n_dt2;
    logic [SQ_W-1:0]         r_d2, n_d2, r_e2, n_e2, r_h2, n_h2;
    logic [T2_W-1:0]         r_t2, n_t2;
    logic signed [OFS_W-1:0] r_off2, n_off2, r_sens2, n_sens2;
    logic signed [OFS_W-1:0] r_soff, n_soff, r_ssens, n_ssens;
    logic signed [PQ_W-1:0]  r_pq, n_pq;

    logic                    r_ovalid, n_ovalid;
    logic                    r_okind, n_okind;
    logic signed [RES_W-1:0] r_otf, n_otf, r_ots, n_ots, r_opr, n_opr;

    t_var                    var_sel;
    logic                    f_low, f_vlow, f_high;
    logic [RAW_W-1:0]        adt;
    logic [ADEV_W-1:0]       ad, ae, ah;
    logic [SH_W-1:0]         ko, so, ks, ss, s_t2, s_o2a, s_s2a;
    logic [2:0]              k_t2, k_s2a;
    logic [5:0]              k_o2a;
    logic [4:0]              k_o2b;
    logic [3:0]              k_s2b;
    logic                    h_s2a;
    logic signed [OFS_W-1:0] sens2a;
    logic signed [PQ_W-1:0]  pq_sh;
    logic signed [RES_W-1:0] pres_sat;

    t_mul_cmd                 mul_cmd;
    t_mul_sts                 mul_sts;
    logic signed [MUL_AW-1:0] m_a;
    logic [MUL_BW-1:0]        m_b;
    logic [CNT_W-1:0]         m_n;
    logic signed [MUL_PW-1:0] prod;

    // variant decode, unused codes behave as the 01 bar part
    always_comb begin
        unique case (r_var)
            VC_02:        var_sel = V_02;
            VC_05:        var_sel = V_05;
            VC_14, VC_30: var_sel = V_14;
            default:      var_sel = V_01;
        endcase
    end

    assign f_low  = r_temp < T_NOM;
    assign f_vlow = r_temp < T_VLOW;
    assign f_high = r_temp > T_HIGH;

    assign adt = r_dt[DT_W-1] ? RAW_W'(-r_dt) : RAW_W'(r_dt);
    assign ad  = abs_dev(DEV_W'(r_temp) - D_NOM);
    assign ae  = abs_dev(DEV_W'(r_temp) + D_VLOW);
    assign ah  = abs_dev(DEV_W'(r_temp) - D_HIGH);

    // per-variant scaling and correction factors
    always_comb begin
        ko    = SH_W'(16);
        so    = SH_W'(7);
        ks    = SH_W'(15);
        ss    = SH_W'(8);
        k_t2  = '0;
        s_t2  = '0;
        k_o2a = '0;
        s_o2a = '0;
        k_o2b = '0;
        k_s2a = '0;
        s_s2a = '0;
        h_s2a = 1'b0;
        k_s2b = '0;
        unique case (var_sel)
            V_02: begin
                ko = SH_W'(17);
                so = SH_W'(6);
                ks = SH_W'(16);
                ss = SH_W'(7);
                if (f_low) begin
                    k_t2  = 3'd3;
                    s_t2  = SH_W'(31);
                    k_o2a = 6'd61;
                    s_o2a = SH_W'(4);
                    k_s2a = 3'd2;
                    if (f_vlow) begin
                        k_o2b = 5'd20;
                        k_s2b = 4'd12;
                    end
                end else if (f_high) begin
                    k_s2a = 3'd1;
                    s_s2a = SH_W'(3);
                    h_s2a = 1'b1;
                end
            end
            V_05: begin
                ko = SH_W'(18);
                so = SH_W'(5);
                ks = SH_W'(17);
                ss = SH_W'(7);
                if (f_low) begin
                    k_t2  = 3'd3;
                    s_t2  = SH_W'(33);
                    k_o2a = 6'd3;
                    s_o2a = SH_W'(3);
                    k_s2a = 3'd7;
                    s_s2a = SH_W'(3);
                    if (f_vlow) begin
                        k_s2b = 4'd3;
                    end
                end
            end
            V_14: begin
                if (f_low) begin
                    k_t2  = 3'd3;
                    s_t2  = SH_W'(33);
                    k_o2a = 6'd3;
                    s_o2a = SH_W'(1);
                    k_s2a = 3'd5;
                    s_s2a = SH_W'(3);
                    if (f_vlow) begin
                        k_o2b = 5'd7;
                        k_s2b = 4'd4;
                    end
                end else begin
                    k_t2  = 3'd7;
                    s_t2  = SH_W'(37);
                    k_o2a = 6'd1;
                    s_o2a = SH_W'(4);
                end
            end
            default: begin
                if (f_low) begin
                    k_t2  = 3'd3;
                    s_t2  = SH_W'(31);
                    k_o2a = 6'd3;
                    k_s2a = 3'd7;
                    s_s2a = SH_W'(3);
                    if (f_vlow) begin
                        k_s2b = 4'd2;
                    end
                end else if (f_high) begin
                    k_s2a = 3'd1;
                    s_s2a = SH_W'(3);
                    h_s2a = 1'b1;
                end
            end
        endcase
    end

    // multiplier operands for the current job
    always_comb begin
        m_a = '0;
        m_b = '0;
        m_n = CNT_W'(1);
        unique case (r_job)
            J_TEMP: begin
                m_a = MUL_AW'(r_dt);
                m_b = MUL_BW'(r_c6);
                m_n = CNT_W'(CAL_W);
            end
            J_OFFT: begin
                m_a = MUL_AW'(r_dt);
                m_b = MUL_BW'(r_c4);
                m_n = CNT_W'(CAL_W);
            end
            J_SENT: begin
                m_a = MUL_AW'(r_dt);
                m_b = MUL_BW'(r_c3);
                m_n = CNT_W'(CAL_W);
            end
            J_DT2: begin
                m_a = signed'(MUL_AW'(adt));
                m_b = MUL_BW'(adt);
                m_n = CNT_W'(RAW_W);
            end
            J_D2: begin
                m_a = signed'(MUL_AW'(ad));
                m_b = MUL_BW'(ad);
                m_n = CNT_W'(ADEV_W);
            end
            J_E2: begin
                m_a = signed'(MUL_AW'(ae));
                m_b = MUL_BW'(ae);
                m_n = CNT_W'(ADEV_W);
            end
            J_H2: begin
                m_a = signed'(MUL_AW'(ah));
                m_b = MUL_BW'(ah);
                m_n = CNT_W'(ADEV_W);
            end
            J_T2: begin
                m_a = signed'(MUL_AW'(r_dt2));
                m_b = MUL_BW'(k_t2);
                m_n = CNT_W'($bits(k_t2));
            end
            J_OFF2A: begin
                m_a = signed'(MUL_AW'(r_d2));
                m_b = MUL_BW'(k_o2a);
                m_n = CNT_W'($bits(k_o2a));
            end
            J_OFF2B: begin
                m_a = signed'(MUL_AW'(r_e2));
                m_b = MUL_BW'(k_o2b);
                m_n = CNT_W'($bits(k_o2b));
            end
            J_SEN2A: begin
                m_a = signed'(MUL_AW'(h_s2a ? r_h2 : r_d2));
                m_b = MUL_BW'(k_s2a);
                m_n = CNT_W'($bits(k_s2a));
            end
            J_SEN2B: begin
                m_a = signed'(MUL_AW'(r_e2));
                m_b = MUL_BW'(k_s2b);
                m_n = CNT_W'($bits(k_s2b));
            end
            J_PRS: begin
                m_a = MUL_AW'(r_ssens);
                m_b = MUL_BW'(r_raw);
                m_n = CNT_W'(RAW_W);
            end
            default: ;
        endcase
    end

    assign mul_cmd.start = (r_state == S_SETUP);
    assign mul_cmd.nbits = m_n;

    psc_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mul_cmd),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_sts   (mul_sts),
        .o_prod  (prod)
    );

    assign sens2a = OFS_W'(prod >>> s_s2a);

    // pressure scaling and saturation
    assign pq_sh = r_pq >>> PO_SH;
    always_comb begin
        priority if (pq_sh > P_MAX) begin
            pres_sat = RES_W'(P_MAX);
        end else if (pq_sh < P_MIN) begin
            pres_sat = RES_W'(P_MIN);
        end else begin
            pres_sat = RES_W'(pq_sh);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_c1     = r_c1;
        n_c2     = r_c2;
        n_c3     = r_c3;
        n_c4     = r_c4;
        n_c5     = r_c5;
        n_c6     = r_c6;
        n_var    = r_var;
        n_op     = r_op;
        n_raw    = r_raw;
        n_dt     = r_dt;
        n_temp   = r_temp;
        n_obase  = r_obase;
        n_sbase  = r_sbase;
        n_dt2    = r_dt2;
        n_d2     = r_d2;
        n_e2     = r_e2;
        n_h2     = r_h2;
        n_t2     = r_t2;
        n_off2   = r_off2;
        n_sens2  = r_sens2;
        n_soff   = r_soff;
        n_ssens  = r_ssens;
        n_pq     = r_pq;
        n_ovalid = r_ovalid;
        n_okind  = r_okind;
        n_otf    = r_otf;
        n_ots    = r_ots;
        n_opr    = r_opr;

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SENS_CAL:   n_c1  = i_cfg.data;
                REG_OFFS_CAL:   n_c2  = i_cfg.data;
                REG_SENS_TCO:   n_c3  = i_cfg.data;
                REG_OFFS_TCO:   n_c4  = i_cfg.data;
                REG_TEMP_REF:   n_c5  = i_cfg.data;
                REG_TEMP_COEFF: n_c6  = i_cfg.data;
                REG_VARIANT:    n_var = i_cfg.data[VAR_W-1:0];
                default: ;
            endcase
        end

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.op;
                    n_raw   = i_in.raw_sample;
                    n_dt    = DT_W'(i_in.raw_sample) - (DT_W'(r_c5) << REF_SH);
                    n_job   = (i_in.op == OP_PRES) ? J_PRS : J_TEMP;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (mul_sts.done) begin
                    n_state = S_SETUP;
                    unique case (r_job)
                        J_TEMP: begin
                            n_temp = TEMP_W'(prod >>> TC_SH) + T_NOM;
                            n_job  = J_OFFT;
                        end
                        J_OFFT: begin
                            n_obase = (OFS_W'(r_c2) << ko) + OFS_W'(prod >>> so);
                            n_job   = J_SENT;
                        end
                        J_SENT: begin
                            n_sbase = (OFS_W'(r_c1) << ks) + OFS_W'(prod >>> ss);
                            n_job   = J_DT2;
                        end
                        J_DT2: begin
                            n_dt2 = DT2_W'(prod);
                            n_job = J_D2;
                        end
                        J_D2: begin
                            n_d2  = SQ_W'(prod);
                            n_job = J_E2;
                        end
                        J_E2: begin
                            n_e2  = SQ_W'(prod);
                            n_job = J_H2;
                        end
                        J_H2: begin
                            n_h2  = SQ_W'(prod);
                            n_job = J_T2;
                        end
                        J_T2: begin
                            n_t2  = T2_W'(prod >>> s_t2);
                            n_job = J_OFF2A;
                        end
                        J_OFF2A: begin
                            n_off2 = OFS_W'(prod >>> s_o2a);
                            n_job  = J_OFF2B;
                        end
                        J_OFF2B: begin
                            n_off2 = r_off2 + OFS_W'(prod);
                            n_job  = J_SEN2A;
                        end
                        J_SEN2A: begin
                            n_sens2 = h_s2a ? -sens2a : sens2a;
                            n_job   = J_SEN2B;
                        end
                        J_SEN2B: begin
                            n_sens2 = r_sens2 + OFS_W'(prod);
                            n_state = S_FIN;
                        end
                        J_PRS: begin
                            n_pq    = PQ_W'(prod >>> PS_SH) - PQ_W'(r_soff);
                            n_state = S_OUT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FIN: begin
                n_soff  = r_obase - r_off2;
                n_ssens = r_sbase - r_sens2;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_okind  = r_op;
                    if (r_op == OP_PRES) begin
                        n_otf = '0;
                        n_ots = '0;
                        n_opr = pres_sat;
                    end else begin
                        n_otf = RES_W'(r_temp);
                        n_ots = RES_W'(r_temp) - RES_W'(r_t2);
                        n_opr = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_job    <= J_TEMP;
            r_c1     <= '0;
            r_c2     <= '0;
            r_c3     <= '0;
            r_c4     <= '0;
            r_c5     <= '0;
            r_c6     <= '0;
            r_var    <= '0;
            r_soff   <= '0;
            r_ssens  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_job    <= n_job;
            r_c1     <= n_c1;
            r_c2     <= n_c2;
            r_c3     <= n_c3;
            r_c4     <= n_c4;
            r_c5     <= n_c5;
            r_c6     <= n_c6;
            r_var    <= n_var;
            r_soff   <= n_soff;
            r_ssens  <= n_ssens;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_raw   <= n_raw;
        r_dt    <= n_dt;
        r_temp  <= n_temp;
        r_obase <= n_obase;
        r_sbase <= n_sbase;
        r_dt2   <= n_dt2;
        r_d2    <= n_d2;
        r_e2    <= n_e2;
        r_h2    <= n_h2;
        r_t2    <= n_t2;
        r_off2  <= n_off2;
        r_sens2 <= n_sens2;
        r_pq    <= n_pq;
        r_okind <= n_okind;
        r_otf   <= n_otf;
        r_ots   <= n_ots;
        r_opr   <= n_opr;
    end

    assign i_in.ready              = (r_state == S_IDLE);
    assign i_cfg.ready             = 1'b1;
    assign o_out.valid             = r_ovalid;
    assign o_out.result_kind       = r_okind;
    assign o_out.temp_first_order  = r_otf;
    assign o_out.temp_second_order = r_ots;
    assign o_out.pressure_value    = r_opr;

    a_wait_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (mul_sts.busy || mul_sts.done))
        else $error("waiting with no multiply in flight");

    a_terms_only_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIN) |=> ($stable(r_soff) && $stable(r_ssens)))
        else $error("stored terms changed outside finish step");

    a_pres_no_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_okind == OP_PRES)) |-> ((r_otf == '0) && (r_ots == '0)))
        else $error("pressure beat carries temperature");

    a_temp_no_pres: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_okind == OP_TEMP)) |-> (r_opr == '0))
        else $error("temperature beat carries pressure");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench for pressure_sensor_compensation_core
// depends on psc_pkg and psc_if; drives conversions and calibration writes,
// predicts every result beat in 64-bit integer arithmetic and compares
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import psc_pkg::*;

    localparam int  CLK_PERIOD  = 10;
    localparam int  RST_CYCLES  = 8;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  RAND_PHASES = 16;
    localparam int  PHASE_ITEMS = 100;
    localparam int  STALL_AT    = 950;
    localparam int  STALL_LEN   = 600;
    localparam int  TAIL_CYCLES = 200;
    localparam int  PRINT_CAP   = 40;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic             op;
        logic [RAW_W-1:0] raw;
    } conv_t;

    typedef struct packed {
        logic                    kind;
        logic signed [RES_W-1:0] t1;
        logic signed [RES_W-1:0] t2;
        logic signed [RES_W-1:0] pres;
    } reading_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    psc_in_if  in_if ();
    psc_out_if out_if ();
    psc_cfg_if cfg_if ();

    pressure_sensor_compensation_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    conv_t    conv_queue[$];
    reading_t reading_queue[$];

    // calibration mirror and kept compensation terms
    logic [CAL_W-1:0] cal_word[0:5];
    logic [VAR_W-1:0] variant_sel;
    longint           kept_offset;
    longint           kept_sens;

    int send_idle_pct;
    int recv_idle_pct;
    logic hold_recv;
    int beats_in;
    int beats_out;
    int temp_beats;
    int pres_beats;
    int cfg_writes;
    int mismatches;
    int cycles;

    function automatic logic signed [RES_W-1:0] clamp32(input longint v);
        if (v > SAT_HI) return SAT_HI[RES_W-1:0];
        if (v < SAT_LO) return SAT_LO[RES_W-1:0];
        return v[RES_W-1:0];
    endfunction

    function automatic reading_t compensate(input conv_t c);
        longint raw, dt, tmp, c1, c2, c3, c4, c5, c6;
        longint offs, sens, t2, off2, sens2, d2, e2, h2, dt2, p;
        reading_t r;
        raw = {40'd0, c.raw};
        r = '0;
        if (c.op == OP_PRES) begin
            p = ((raw * kept_sens) >>> 21) - kept_offset;
            r.kind = OP_PRES;
            r.pres = clamp32(p >>> 15);
            return r;
        end
        c1 = {48'd0, cal_word[REG_SENS_CAL]};
        c2 = {48'd0, cal_word[REG_OFFS_CAL]};
        c3 = {48'd0, cal_word[REG_SENS_TCO]};
        c4 = {48'd0, cal_word[REG_OFFS_TCO]};
        c5 = {48'd0, cal_word[REG_TEMP_REF]};
        c6 = {48'd0, cal_word[REG_TEMP_COEFF]};
        dt = raw - c5 * 256;
        tmp = 2000 + ((dt * c6) >>> 23);
        d2 = (tmp - 2000) * (tmp - 2000);
        e2 = (tmp + 1500) * (tmp + 1500);
        h2 = (tmp - 4500) * (tmp - 4500);
        dt2 = dt * dt;
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        case (variant_sel)
            VC_02: begin
                offs = c2 * 131072 + ((c4 * dt) >>> 6);
                sens = c1 * 65536 + ((c3 * dt) >>> 7);
                if (tmp < 2000) begin
                    t2 = (3 * dt2) >>> 31;
                    off2 = (61 * d2) >>> 4;
                    sens2 = 2 * d2;
                    if (tmp < -1500) begin
                        off2 += 20 * e2;
                        sens2 += 12 * e2;
                    end
                end else if (tmp > 4500) begin
                    sens2 = -(h2 >>> 3);
                end
            end
            VC_05: begin
                offs = c2 * 262144 + ((c4 * dt) >>> 5);
                sens = c1 * 131072 + ((c3 * dt) >>> 7);
                if (tmp < 2000) begin
                    t2 = (3 * dt2) >>> 33;
                    off2 = (3 * d2) >>> 3;
                    sens2 = (7 * d2) >>> 3;
                    if (tmp < -1500) sens2 += 3 * e2;
                end
            end
            VC_14, VC_30: begin
                offs = c2 * 65536 + ((c4 * dt) >>> 7);
                sens = c1 * 32768 + ((c3 * dt) >>> 8);
                if (tmp < 2000) begin
                    t2 = (3 * dt2) >>> 33;
                    off2 = (3 * d2) >>> 1;
                    sens2 = (5 * d2) >>> 3;
                    if (tmp < -1500) begin
                        off2 += 7 * e2;
                        sens2 += 4 * e2;
                    end
                end else begin
                    t2 = (7 * dt2) >>> 37;
                    off2 = d2 >>> 4;
                end
            end
            default: begin
                offs = c2 * 65536 + ((c4 * dt) >>> 7);
                sens = c1 * 32768 + ((c3 * dt) >>> 8);
                if (tmp < 2000) begin
                    t2 = (3 * dt2) >>> 31;
                    off2 = 3 * d2;
                    sens2 = (7 * d2) >>> 3;
                    if (tmp < -1500) sens2 += 2 * e2;
                end else if (tmp > 4500) begin
                    sens2 = -(h2 >>> 3);
                end
            end
        endcase
        kept_offset = offs - off2;
        kept_sens = sens - sens2;
        r.kind = OP_TEMP;
        r.t1 = clamp32(tmp);
        r.t2 = clamp32(tmp - t2);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_CAP)
            $display("%0t: beat %0d %s: got %0d, expected %0d", $time, beats_out, what, got,
                     want);
        mismatches++;
    endtask

    // conversion driver
    always @(posedge i_clk) begin : conv_driver
        conv_t c;
        logic  slot_free;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            slot_free = !in_if.valid || in_if.ready;
            if (in_if.valid && in_if.ready) begin
                reading_queue.push_back(compensate('{in_if.op, in_if.raw_sample}));
                beats_in++;
            end
            if (slot_free) begin
                if (conv_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = conv_queue.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.op         <= c.op;
                    in_if.raw_sample <= c.raw;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : reading_monitor
        reading_t want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                beats_out++;
                if (reading_queue.size() == 0) begin
                    note_mismatch("beat with nothing pending", 0, 0);
                end else begin
                    want = reading_queue.pop_front();
                    if (want.kind == OP_TEMP) temp_beats++;
                    else pres_beats++;
                    if (out_if.result_kind !== want.kind)
                        note_mismatch("result_kind", out_if.result_kind, want.kind);
                    if (out_if.temp_first_order !== want.t1)
                        note_mismatch("temp_first_order", out_if.temp_first_order, want.t1);
                    if (out_if.temp_second_order !== want.t2)
                        note_mismatch("temp_second_order", out_if.temp_second_order, want.t2);
                    if (out_if.pressure_value !== want.pres)
                        note_mismatch("pressure_value", out_if.pressure_value, want.pres);
                end
            end
            out_if.ready <= !hold_recv && $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     reading_queue.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // long output stall so the core backs up and stalls its input
    initial begin : output_stall
        wait (beats_in >= STALL_AT);
        @(posedge i_clk);
        hold_recv <= 1'b1;
        repeat (STALL_LEN) @(posedge i_clk);
        hold_recv <= 1'b0;
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_VARIANT: variant_sel = val[VAR_W-1:0];
            REG_SENS_CAL, REG_OFFS_CAL, REG_SENS_TCO, REG_OFFS_TCO, REG_TEMP_REF,
            REG_TEMP_COEFF: cal_word[idx] = val;
            default: ;
        endcase
    endtask

    task automatic set_cal(input logic [CAL_W-1:0] c1, c2, c3, c4, c5, c6, vsel);
        write_reg(REG_SENS_CAL, c1);
        write_reg(REG_OFFS_CAL, c2);
        write_reg(REG_SENS_TCO, c3);
        write_reg(REG_OFFS_TCO, c4);
        write_reg(REG_TEMP_REF, c5);
        write_reg(REG_TEMP_COEFF, c6);
        write_reg(REG_VARIANT, vsel);
    endtask

    task automatic add_conv(input logic op, input logic [RAW_W-1:0] raw);
        conv_queue.push_back('{op, raw});
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (conv_queue.size() != 0 || in_if.valid || reading_queue.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [CAL_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return CAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // half random raw values with extremes, half near the reference temperature point
    function automatic logic [RAW_W-1:0] pick_temp_raw();
        longint v;
        if ($urandom_range(1) == 0) return pick_raw();
        v = {48'd0, cal_word[REG_TEMP_REF]} * 256 + longint'($urandom_range(0, 2097152))
            - 1048576;
        if (v < 0) v = 0;
        if (v > 16777215) v = 16777215;
        return v[RAW_W-1:0];
    endfunction

    initial begin : stimulus
        logic [CAL_W-1:0] w[0:5];
        int ph;
        int n;
        in_if.valid      = 1'b0;
        in_if.op         = OP_TEMP;
        in_if.raw_sample = '0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        hold_recv        = 1'b0;
        send_idle_pct    = 8;
        recv_idle_pct    = 48;
        for (int k = 0; k < 6; k++) cal_word[k] = '0;
        variant_sel = '0;
        kept_offset = 0;
        kept_sens   = 0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset calibration, pressure before any temperature
        add_conv(OP_PRES, 24'hffffff);
        add_conv(OP_TEMP, 24'd0);
        add_conv(OP_TEMP, 24'hffffff);
        add_conv(OP_PRES, 24'hffffff);
        add_conv(OP_PRES, 24'd0);
        wait_idle();

        // temperature at 2000, 4500 and just above
        set_cal(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd0, 16'h8000, 16'd0);
        add_conv(OP_TEMP, 24'd0);
        add_conv(OP_PRES, 24'hffffff);
        add_conv(OP_TEMP, 24'd640000);
        add_conv(OP_PRES, 24'd0);
        add_conv(OP_TEMP, 24'd640256);
        add_conv(OP_PRES, 24'hffffff);
        add_conv(OP_TEMP, 24'hffffff);
        add_conv(OP_PRES, 24'hffffff);
        wait_idle();

        // temperature at -1500 and low
        set_cal(16'hffff, 16'h8000, 16'hffff, 16'd0, 16'd3500, 16'h8000, {13'd0, VC_02});
        add_conv(OP_TEMP, 24'd0);
        add_conv(OP_PRES, 24'hffffff);
        add_conv(OP_TEMP, 24'd512000);
        add_conv(OP_PRES, 24'habcdef);
        wait_idle();

        // just below -1500
        set_cal(16'h1234, 16'hffff, 16'h5678, 16'hffff, 16'd3501, 16'h8000, {13'd0, VC_14});
        add_conv(OP_TEMP, 24'd0);
        add_conv(OP_PRES, 24'hffffff);
        add_conv(OP_TEMP, 24'hffffff);
        wait_idle();

        // every calibration word at its maximum
        set_cal('1, '1, '1, '1, '1, '1, {13'd0, VC_30});
        add_conv(OP_TEMP, 24'd0);
        add_conv(OP_PRES, 24'hffffff);
        add_conv(OP_TEMP, 24'hffffff);
        wait_idle();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 5) begin
                send_idle_pct = 48;
                recv_idle_pct = 8;
            end
            if (ph == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < 6; k++)
                w[k] = (ph == 1) ? '0 : (ph == 2) ? '1 : pick_word();
            set_cal(w[0], w[1], w[2], w[3], w[4], w[5],
                    {13'($urandom_range(0, 8191)), 3'(ph % 8)});
            write_reg(REG_UNUSED, CAL_W'($urandom));
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(9) < 8) begin
                    add_conv(OP_TEMP, pick_temp_raw());
                    n++;
                    repeat ($urandom_range(1, 4)) begin
                        add_conv(OP_PRES, pick_raw());
                        n++;
                    end
                end else begin
                    add_conv(1'($urandom), RAW_W'($urandom));
                    n++;
                end
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (reading_queue.size() != 0)
            note_mismatch("results never delivered", 0, reading_queue.size());
        $display("checked %0d result beats (%0d temperature, %0d pressure) from %0d conversions",
                 beats_out, temp_beats, pres_beats, beats_in);
        $display("%0d register writes, all variant codes, calibration extremes, one long stall",
                 cfg_writes);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ pressure_sensor_compensation_core.f @@
design/psc_pkg.sv
design/psc_if.sv
design/psc_smul.sv
design/pressure_sensor_compensation_core.sv
sim/tb.sv
